// ===== design/pbs_pkg.sv =====
// Shared constants, types and command/status structs for the PCG32 byte stream unit.
`timescale 1ns / 1ps
`default_nettype none

package pbs_pkg;

  // LCG multiplier and increment
  localparam logic [63:0] LCG_MUL = 64'h5851F42D4C957F2D;
  localparam logic [63:0] LCG_INC = 64'hDD5C0E28D9236311;

  // State after reset: seed of zero, then one advance
  localparam logic [63:0] RESET_STATE = LCG_INC * LCG_MUL + LCG_INC;

  // Output permutation shifts
  localparam int unsigned XS_SHIFT = 18;
  localparam int unsigned WORD_LSB = 27;
  localparam int unsigned ROT_LSB  = 59;
  localparam int unsigned WORD_W   = 32;

  localparam int unsigned MAX_BYTES_DEFAULT = 64;

  typedef enum logic {
    CMD_GENERATE = 1'b0,
    CMD_RESEED   = 1'b1
  } pbs_op_t;

  // Controller to datapath
  typedef struct packed {
    logic       seed_load;  // state <= seed + inc, then advance
    logic       draw;       // capture output word, then advance
    logic       load_out;   // load the selected byte into the output register
    logic [1:0] lane;       // byte of the word to send
  } pbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic adv_busy;
  } pbs_status_t;

endpackage

`default_nettype wire

// ===== design/pbs_dp.sv =====
// Datapath: generator state, four-step shared-multiplier advance, output word and byte register.
`timescale 1ns / 1ps
`default_nettype none

module pbs_dp
  import pbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [63:0] seed_value,
  input  wire pbs_cmd_t    ctl,
  output pbs_status_t      status,
  output logic [7:0]       random_byte
);

  typedef enum logic [1:0] {
    STEP_LO_LO,
    STEP_HI_LO,
    STEP_LO_HI,
    STEP_FOLD
  } adv_step_t;

  logic [63:0] state;
  logic        busy;
  adv_step_t   step;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] word;
  logic [31:0] acc_hi_sum;

  function automatic logic [31:0] xsh_rr(input logic [63:0] x);
    logic [63:0] xs;
    logic [31:0] w;
    logic [63:0] dbl;
    xs  = x ^ (x >> XS_SHIFT);
    w   = xs[WORD_LSB +: WORD_W];
    dbl = {w, w} >> x[ROT_LSB +: 5];
    return dbl[31:0];
  endfunction

  // Operand select for the shared 32x32 multiplier
  always_comb begin
    case (step)
      STEP_LO_LO: begin
        mul_a = state[31:0];
        mul_b = LCG_MUL[31:0];
      end
      STEP_HI_LO: begin
        mul_a = state[63:32];
        mul_b = LCG_MUL[31:0];
      end
      STEP_LO_HI: begin
        mul_a = state[31:0];
        mul_b = LCG_MUL[63:32];
      end
      default: begin
        mul_a = state[31:0];
        mul_b = LCG_MUL[31:0];
      end
    endcase
  end

  assign acc_hi_sum = acc[63:32] + prod[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RESET_STATE;
      busy  <= 1'b0;
      step  <= STEP_LO_LO;
    end else if (ctl.seed_load) begin
      state <= seed_value + LCG_INC;
      busy  <= 1'b1;
      step  <= STEP_LO_LO;
    end else if (ctl.draw) begin
      busy <= 1'b1;
      step <= STEP_LO_LO;
    end else if (busy) begin
      case (step)
        STEP_LO_LO: step <= STEP_HI_LO;
        STEP_HI_LO: step <= STEP_LO_HI;
        STEP_LO_HI: step <= STEP_FOLD;
        default: begin
          // fold the last cross product into the high half
          state <= {acc_hi_sum, acc[31:0]};
          busy  <= 1'b0;
          step  <= STEP_LO_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (busy) begin
      case (step)
        STEP_HI_LO: acc <= prod + LCG_INC;
        STEP_LO_HI: acc <= {acc_hi_sum, acc[31:0]};
        default:    acc <= acc;
      endcase
    end
    if (ctl.draw) begin
      word <= xsh_rr(state);
    end
    if (ctl.load_out) begin
      random_byte <= word[{ctl.lane, 3'b000} +: 8];
    end
  end

  assign status.adv_busy = busy;

endmodule

`default_nettype wire

// ===== design/pbs_ctl.sv =====
// Controller: command handshake, byte run sequencing and output valid/last flags.
`timescale 1ns / 1ps
`default_nettype none

module pbs_ctl
  import pbs_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic        command,
  input  wire logic [6:0]  byte_count,
  output logic             byte_valid,
  input  wire logic        byte_stall,
  output logic             last_byte,
  output pbs_cmd_t         ctl,
  input  wire pbs_status_t status
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_EMIT
  } ctl_state_t;

  ctl_state_t       fsm;
  logic [CNT_W-1:0] remaining;
  logic [1:0]       lane;
  logic [CNT_W-1:0] sat_count;
  logic             cmd_take;
  logic             slot_free;

  assign cmd_stall = (fsm != S_IDLE) || status.adv_busy;
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign slot_free = !byte_valid || !byte_stall;

  // clamp the request to the largest run
  assign sat_count = (byte_count > 7'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : CNT_W'(byte_count);

  always_comb begin
    ctl.seed_load = 1'b0;
    ctl.draw      = 1'b0;
    ctl.load_out  = 1'b0;
    ctl.lane      = lane;
    unique case (fsm)
      S_IDLE: ctl.seed_load = cmd_take && (command == CMD_RESEED);
      S_DRAW: ctl.draw      = !status.adv_busy;
      S_EMIT: ctl.load_out  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= S_IDLE;
      remaining  <= '0;
      lane       <= '0;
      byte_valid <= 1'b0;
      last_byte  <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        byte_valid <= 1'b0;
      end
      unique case (fsm)
        S_IDLE: begin
          if (cmd_take && (command == CMD_GENERATE) && (sat_count != '0)) begin
            remaining <= sat_count;
            fsm       <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (!status.adv_busy) begin
            lane <= '0;
            fsm  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            byte_valid <= 1'b1;
            last_byte  <= (remaining == CNT_W'(1));
            remaining  <= remaining - CNT_W'(1);
            lane       <= lane + 2'd1;
            if (remaining == CNT_W'(1)) begin
              fsm <= S_IDLE;
            end else if (lane == 2'd3) begin
              fsm <= S_DRAW;
            end
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/pcg32_byte_stream_unit.sv =====
// Top level of the PCG32 XSH-RR byte stream unit.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+----------------------------------------
//   command | cmd_valid  | cmd_stall  | command, seed_value, byte_count
//   bytes   | byte_valid | byte_stall | random_byte, last_byte
//
// A generate of n bytes runs in groups of four: the word is captured and the state
// advance started, then one byte is sent per cycle while the output is not stalled.
// The advance uses one shared 32x32 multiplier and overlaps the bytes of its group.
// A reseed loads the seed and runs the advance before the next command is taken.
// Reset loads the state seeded with zero. A stalled byte holds the run in place.
`timescale 1ns / 1ps
`default_nettype none

module pcg32_byte_stream_unit
  import pbs_pkg::*;
#(
  parameter int unsigned MAX_BYTES_PER_REQUEST = MAX_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic        command,
  input  wire logic [63:0] seed_value,
  input  wire logic [6:0]  byte_count,
  output logic             byte_valid,
  input  wire logic        byte_stall,
  output logic [7:0]       random_byte,
  output logic             last_byte
);

  pbs_cmd_t    ctl;
  pbs_status_t status;

  pbs_ctl #(
    .MAX_BYTES(MAX_BYTES_PER_REQUEST)
  ) u_ctl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .byte_count (byte_count),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .last_byte  (last_byte),
    .ctl        (ctl),
    .status     (status)
  );

  pbs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .seed_value  (seed_value),
    .ctl         (ctl),
    .status      (status),
    .random_byte (random_byte)
  );

  // a new word is never captured while the previous advance is in flight
  assert property (@(posedge clk) disable iff (rst) ctl.draw |-> !status.adv_busy)
    else $error("word drawn during state advance");

  // a byte never overwrites one that is still stalled
  assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> !(byte_valid && byte_stall))
    else $error("output byte overwritten while stalled");

  // an accepted reseed always starts an advance
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && (command == CMD_RESEED)) |=> status.adv_busy)
    else $error("reseed transaction did not start an advance");

  // no command is taken while a byte run is in progress
  assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !last_byte) |-> cmd_stall)
    else $error("command transaction accepted mid-run");

endmodule

`default_nettype wire
